[hw/rtl/sha1s_pkg.sv]
package sha1s_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned BlkWords = 16;
  localparam int unsigned Rounds  = 80;
  localparam int unsigned PosW    = 6;
  localparam int unsigned RndW    = 7;
  localparam int unsigned CountW  = 64;

  localparam logic [PosW-1:0] LastPos  = 6'd63;
  localparam logic [PosW-1:0] LenPos   = 6'd56;
  localparam logic [RndW-1:0] LastRnd  = 7'd79;
  localparam logic [RndW-1:0] Phase1Rnd = 7'd20;
  localparam logic [RndW-1:0] Phase2Rnd = 7'd40;
  localparam logic [RndW-1:0] Phase3Rnd = 7'd60;
  localparam logic [7:0]      PadMark  = 8'h80;

  localparam logic [WordW-1:0] IV [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  typedef enum logic [1:0] {
    PH_CH  = 2'd0,
    PH_P1  = 2'd1,
    PH_MAJ = 2'd2,
    PH_P2  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    SEL_MSG  = 2'd0,
    SEL_MARK = 2'd1,
    SEL_ZERO = 2'd2,
    SEL_LEN  = 2'd3
  } byte_sel_t;

  typedef struct packed {
    logic      shift;
    byte_sel_t sel;
    logic      count_inc;
    logic      load_work;
    logic      round_en;
    phase_t    phase;
    logic      add_chain;
    logic      init_chain;
  } cmd_t;

  typedef struct packed {
    logic [PosW-1:0] pos;
  } status_t;

  function automatic logic [WordW-1:0] round_k(input phase_t ph);
    logic [WordW-1:0] k;
    case (ph)
      PH_CH:   k = 32'h5A827999;
      PH_P1:   k = 32'h6ED9EBA1;
      PH_MAJ:  k = 32'h8F1BBCDC;
      default: k = 32'hCA62C1D6;
    endcase
    return k;
  endfunction

  function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] x, input int unsigned n);
    return (x << n) | (x >> (WordW - n));
  endfunction

endpackage

[hw/rtl/sha1s_datapath.sv]
module sha1s_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  sha1s_pkg::cmd_t      cmd,
  output sha1s_pkg::status_t   status,
  input  logic [7:0]           data_byte,
  output logic [31:0]          digest_w0,
  output logic [31:0]          digest_w1,
  output logic [31:0]          digest_w2,
  output logic [31:0]          digest_w3,
  output logic [31:0]          digest_w4
);

  logic [sha1s_pkg::WordW-1:0]  w [sha1s_pkg::BlkWords];
  logic [sha1s_pkg::WordW-1:0]  h [5];
  logic [sha1s_pkg::WordW-1:0]  a, b, c, d, e;
  logic [sha1s_pkg::CountW-1:0] count;
  logic [sha1s_pkg::PosW-1:0]   pos;

  logic [7:0]                   in_byte;
  logic [sha1s_pkg::CountW-1:0] bit_len;
  logic [sha1s_pkg::CountW-1:0] len_shift;
  logic [sha1s_pkg::WordW-1:0]  f;
  logic [sha1s_pkg::WordW-1:0]  tmp;
  logic [sha1s_pkg::WordW-1:0]  w_new;

  assign bit_len   = {count[sha1s_pkg::CountW-4:0], 3'b000};
  assign len_shift = bit_len << {pos[2:0], 3'b000};

  always_comb begin
    case (cmd.sel)
      sha1s_pkg::SEL_MSG:  in_byte = data_byte;
      sha1s_pkg::SEL_MARK: in_byte = sha1s_pkg::PadMark;
      sha1s_pkg::SEL_LEN:  in_byte = len_shift[sha1s_pkg::CountW-1 -: 8];
      default:             in_byte = 8'h00;
    endcase
  end

  always_comb begin
    case (cmd.phase)
      sha1s_pkg::PH_CH:  f = d ^ (b & (c ^ d));
      sha1s_pkg::PH_MAJ: f = (b & c) | (d & (b | c));
      default:           f = b ^ c ^ d;
    endcase
  end

  assign tmp   = sha1s_pkg::rotl(a, 5) + f + e + sha1s_pkg::round_k(cmd.phase) + w[0];
  assign w_new = sha1s_pkg::rotl(w[13] ^ w[8] ^ w[2] ^ w[0], 1);

  // message schedule doubles as the byte gather buffer
  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      for (int i = 0; i < sha1s_pkg::BlkWords - 1; i++) begin
        w[i] <= {w[i][23:0], w[i+1][31:24]};
      end
      w[sha1s_pkg::BlkWords-1] <= {w[sha1s_pkg::BlkWords-1][23:0], in_byte};
    end else if (cmd.round_en) begin
      for (int i = 0; i < sha1s_pkg::BlkWords - 1; i++) begin
        w[i] <= w[i+1];
      end
      w[sha1s_pkg::BlkWords-1] <= w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_work) begin
      a <= h[0];
      b <= h[1];
      c <= h[2];
      d <= h[3];
      e <= h[4];
    end else if (cmd.round_en) begin
      a <= tmp;
      b <= a;
      c <= sha1s_pkg::rotl(b, 30);
      d <= c;
      e <= d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.init_chain) begin
      for (int i = 0; i < 5; i++) begin
        h[i] <= sha1s_pkg::IV[i];
      end
      count <= '0;
      pos   <= '0;
    end else begin
      if (cmd.add_chain) begin
        h[0] <= h[0] + a;
        h[1] <= h[1] + b;
        h[2] <= h[2] + c;
        h[3] <= h[3] + d;
        h[4] <= h[4] + e;
      end
      if (cmd.count_inc) begin
        count <= count + 1'b1;
      end
      if (cmd.shift) begin
        pos <= pos + 1'b1;
      end
    end
  end

  assign status.pos = pos;
  assign digest_w0  = h[0];
  assign digest_w1  = h[1];
  assign digest_w2  = h[2];
  assign digest_w3  = h[3];
  assign digest_w4  = h[4];

endmodule

[hw/rtl/sha1s_ctrl.sv]
module sha1s_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                byte_present,
  input  logic                message_end,
  output logic                out_valid,
  input  logic                out_ready,
  output sha1s_pkg::cmd_t     cmd,
  input  sha1s_pkg::status_t  status
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ROUND = 5'b00010,
    S_ADD   = 5'b00100,
    S_PAD   = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t                     state, state_next;
  logic [sha1s_pkg::RndW-1:0] rnd, rnd_next;
  logic                       end_pending, end_pending_next;
  logic                       first, first_next;
  logic                       spill, spill_next;
  logic                       final_blk, final_blk_next;
  logic                       spill_eff;
  logic                       in_acc;
  logic                       tail;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign in_acc    = in_valid && in_ready;
  assign tail      = (status.pos >= sha1s_pkg::LenPos);
  assign spill_eff = spill || (first && tail);

  always_comb begin
    state_next       = state;
    rnd_next         = rnd;
    end_pending_next = end_pending;
    first_next       = first;
    spill_next       = spill;
    final_blk_next   = final_blk;
    cmd              = '0;
    cmd.sel          = sha1s_pkg::SEL_MSG;

    if (rnd < sha1s_pkg::Phase1Rnd) begin
      cmd.phase = sha1s_pkg::PH_CH;
    end else if (rnd < sha1s_pkg::Phase2Rnd) begin
      cmd.phase = sha1s_pkg::PH_P1;
    end else if (rnd < sha1s_pkg::Phase3Rnd) begin
      cmd.phase = sha1s_pkg::PH_MAJ;
    end else begin
      cmd.phase = sha1s_pkg::PH_P2;
    end

    case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (byte_present) begin
            cmd.shift     = 1'b1;
            cmd.count_inc = 1'b1;
          end
          if (byte_present && status.pos == sha1s_pkg::LastPos) begin
            cmd.load_work    = 1'b1;
            end_pending_next = message_end;
            first_next       = message_end;
            final_blk_next   = 1'b0;
            state_next       = S_ROUND;
          end else if (message_end) begin
            first_next = 1'b1;
            spill_next = 1'b0;
            state_next = S_PAD;
          end
        end
      end
      S_PAD: begin
        cmd.shift = 1'b1;
        if (first) begin
          cmd.sel    = sha1s_pkg::SEL_MARK;
          first_next = 1'b0;
          spill_next = tail;
        end else if (tail && !spill) begin
          cmd.sel = sha1s_pkg::SEL_LEN;
        end else begin
          cmd.sel = sha1s_pkg::SEL_ZERO;
        end
        if (status.pos == sha1s_pkg::LastPos) begin
          cmd.load_work    = 1'b1;
          final_blk_next   = !spill_eff;
          end_pending_next = spill_eff;
          spill_next       = 1'b0;
          state_next       = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd.round_en = 1'b1;
        if (rnd == sha1s_pkg::LastRnd) begin
          rnd_next   = '0;
          state_next = S_ADD;
        end else begin
          rnd_next = rnd + 1'b1;
        end
      end
      S_ADD: begin
        cmd.add_chain = 1'b1;
        if (final_blk) begin
          state_next = S_OUT;
        end else if (end_pending) begin
          end_pending_next = 1'b0;
          spill_next       = 1'b0;
          state_next       = S_PAD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          cmd.init_chain = 1'b1;
          final_blk_next = 1'b0;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rnd         <= '0;
      end_pending <= 1'b0;
      first       <= 1'b0;
      spill       <= 1'b0;
      final_blk   <= 1'b0;
    end else begin
      state       <= state_next;
      rnd         <= rnd_next;
      end_pending <= end_pending_next;
      first       <= first_next;
      spill       <= spill_next;
      final_blk   <= final_blk_next;
    end
  end

  a_rnd_idle: assert property (@(posedge clk) disable iff (rst)
    (state != S_ROUND) |-> (rnd == '0))
    else $error("round counter running outside compression");

  a_rnd_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && rnd == sha1s_pkg::LastRnd) |=> (state == S_ADD))
    else $error("compression did not end after last round");

  a_load_full: assert property (@(posedge clk) disable iff (rst)
    cmd.load_work |-> (status.pos == sha1s_pkg::LastPos && cmd.shift))
    else $error("compression started on a partial block");

  a_out_aligned: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> (status.pos == '0 && !end_pending))
    else $error("digest presented with block data pending");

endmodule

[hw/rtl/sha1_stream_hash_top.sv]
// Streaming SHA-1 hasher. One input transaction per cycle is taken while the
// block buffer fills (in_ready high); a 64-byte block then runs 80 rounds on
// a single round unit followed by the chaining add. At message end the padding
// and length bytes are shifted in one per cycle, paused while one or two more
// compressions run, and the digest is held on digest_w0..digest_w4 with
// out_valid until taken; no input is taken while hashing or while the digest
// waits.
module sha1_stream_hash_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        message_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_w0,
  output logic [31:0] digest_w1,
  output logic [31:0] digest_w2,
  output logic [31:0] digest_w3,
  output logic [31:0] digest_w4
);

  sha1s_pkg::cmd_t    cmd;
  sha1s_pkg::status_t status;

  sha1s_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .byte_present (byte_present),
    .message_end  (message_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cmd          (cmd),
    .status       (status)
  );

  sha1s_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .data_byte (data_byte),
    .digest_w0 (digest_w0),
    .digest_w1 (digest_w1),
    .digest_w2 (digest_w2),
    .digest_w3 (digest_w3),
    .digest_w4 (digest_w4)
  );

endmodule
